@@ rtl/mbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse beacon sequencer package
// Shared types, constants and the message and code tables of the keyer.
// ----------------------------------------------------------------------------
package mbs_pkg;

   localparam int MessageLength = 11;
   localparam int RomDepth      = 11;
   localparam int DurWidth      = 16;
   localparam int CharWidth     = 8;
   localparam int SymWidth      = 3;
   localparam int LenWidth      = 3;
   localparam int CsrIndexWidth = 3;

   typedef enum logic [2:0] {
      PhaseBegin = 3'd0,
      PhaseMark  = 3'd1,
      PhaseIntra = 3'd2,
      PhaseInter = 3'd3,
      PhasePost  = 3'd4
   } phase_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      RegDot          = 3'd0,
      RegDash         = 3'd1,
      RegIntraGap     = 3'd2,
      RegInterCharGap = 3'd3,
      RegPostMessage  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [DurWidth-1:0] dot;
      logic [DurWidth-1:0] dash;
      logic [DurWidth-1:0] intra_gap;
      logic [DurWidth-1:0] inter_char_gap;
      logic [DurWidth-1:0] post_message;
   } cfg_type;

   // Symbol count and pattern; bit i of the pattern is symbol i, 1 for a dash.
   typedef struct packed {
      logic [LenWidth-1:0]  len;
      logic [CharWidth-1:0] pattern;
   } code_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_position;
      phase_type            phase;
      logic                 key;
   } rsp_type;

   function automatic logic [CharWidth-1:0] rom_char(input logic [CharWidth-1:0] idx);
      logic [CharWidth-1:0] ch;
      case (idx)
         8'd0:    ch = "G";
         8'd1:    ch = "W";
         8'd2:    ch = "O";
         8'd3:    ch = "T";
         8'd4:    ch = ".";
         8'd5:    ch = "E";
         8'd6:    ch = "N";
         8'd7:    ch = "E";
         8'd8:    ch = "R";
         8'd9:    ch = "G";
         8'd10:   ch = "Y";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic code_type code_of(input logic [CharWidth-1:0] ch);
      code_type c;
      case (ch)
         "G":     c = '{len: 3'd3, pattern: 8'h03};
         "W":     c = '{len: 3'd3, pattern: 8'h06};
         "O":     c = '{len: 3'd3, pattern: 8'h07};
         "T":     c = '{len: 3'd1, pattern: 8'h01};
         ".":     c = '{len: 3'd6, pattern: 8'h2A};
         "E":     c = '{len: 3'd1, pattern: 8'h00};
         "N":     c = '{len: 3'd2, pattern: 8'h01};
         "R":     c = '{len: 3'd3, pattern: 8'h02};
         "Y":     c = '{len: 3'd4, pattern: 8'h0D};
         default: c = '{len: 3'd0, pattern: 8'h00};
      endcase
      return c;
   endfunction

   // Characters beyond the message store have no code.
   function automatic code_type current_code(input logic [CharWidth-1:0] idx);
      code_type c;
      if (idx < CharWidth'(RomDepth)) begin
         c = code_of(rom_char(idx));
      end else begin
         c = '{len: '0, pattern: '0};
      end
      return c;
   endfunction

endpackage

@@ rtl/mbs_csr_regs.sv @@
// ----------------------------------------------------------------------------
// Morse beacon timing registers
// Holds the five duration registers written through the plain write port.
// ----------------------------------------------------------------------------
module mbs_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mbs_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mbs_pkg::DurWidth-1:0]        csr_wdata,
   output mbs_pkg::cfg_type                    cfg
);
   import mbs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            RegDot:          cfg_in.dot            = csr_wdata;
            RegDash:         cfg_in.dash           = csr_wdata;
            RegIntraGap:     cfg_in.intra_gap      = csr_wdata;
            RegInterCharGap: cfg_in.inter_char_gap = csr_wdata;
            RegPostMessage:  cfg_in.post_message   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot            <= 16'd100;
         cfg_ff.dash           <= 16'd300;
         cfg_ff.intra_gap      <= 16'd100;
         cfg_ff.inter_char_gap <= 16'd300;
         cfg_ff.post_message   <= 16'd5000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/mbs_keyer_core.sv @@
// ----------------------------------------------------------------------------
// Morse beacon keyer core
// Phase, countdown, index and key registers with their next-state logic.
// ----------------------------------------------------------------------------
module mbs_keyer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             tick,
   input  mbs_pkg::cfg_type cfg,
   output mbs_pkg::rsp_type next_rsp
);
   import mbs_pkg::*;

   phase_type               phase_ff,     phase_in;
   logic [DurWidth-1:0]     remaining_ff, remaining_in;
   logic [CharWidth-1:0]    char_ff,      char_in;
   logic [SymWidth-1:0]     sym_ff,       sym_in;
   logic                    key_ff,       key_in;

   code_type                code;
   code_type                first_code;
   logic [DurWidth-1:0]     remaining_dec;
   logic [SymWidth-1:0]     sym_inc;
   logic [CharWidth-1:0]    char_inc;

   assign code          = current_code(char_ff);
   assign first_code    = current_code('0);
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - 16'd1 : remaining_ff;
   assign sym_inc       = sym_ff + 3'd1;
   assign char_inc      = char_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      char_in      = char_ff;
      sym_in       = sym_ff;
      key_in       = key_ff;
      if (accept && tick) begin
         remaining_in = remaining_dec;
         if (remaining_dec == '0) begin
            case (phase_ff)
               PhaseBegin: begin
                  char_in = '0;
                  sym_in  = '0;
                  if (first_code.len == '0) begin
                     key_in       = 1'b0;
                     phase_in     = PhaseInter;
                     remaining_in = cfg.inter_char_gap;
                  end else begin
                     key_in       = 1'b1;
                     phase_in     = PhaseMark;
                     remaining_in = first_code.pattern[0] ? cfg.dash : cfg.dot;
                  end
               end
               PhaseMark: begin
                  key_in = 1'b0;
                  sym_in = sym_inc;
                  if (sym_inc >= code.len) begin
                     char_in = char_inc;
                     if (char_inc >= CharWidth'(MessageLength)) begin
                        phase_in     = PhasePost;
                        remaining_in = cfg.post_message;
                     end else begin
                        phase_in     = PhaseInter;
                        remaining_in = cfg.inter_char_gap;
                     end
                  end else begin
                     phase_in     = PhaseIntra;
                     remaining_in = cfg.intra_gap;
                  end
               end
               PhaseIntra: begin
                  key_in       = 1'b1;
                  phase_in     = PhaseMark;
                  remaining_in = code.pattern[sym_ff] ? cfg.dash : cfg.dot;
               end
               PhaseInter: begin
                  sym_in = '0;
                  if (code.len == '0) begin
                     // A character without a code costs one more gap.
                     key_in  = 1'b0;
                     char_in = char_inc;
                     if (char_inc >= CharWidth'(MessageLength)) begin
                        phase_in     = PhasePost;
                        remaining_in = cfg.post_message;
                     end else begin
                        phase_in     = PhaseInter;
                        remaining_in = cfg.inter_char_gap;
                     end
                  end else begin
                     key_in       = 1'b1;
                     phase_in     = PhaseMark;
                     remaining_in = code.pattern[0] ? cfg.dash : cfg.dot;
                  end
               end
               default: begin
                  key_in       = 1'b0;
                  phase_in     = PhaseBegin;
                  remaining_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhaseBegin;
         remaining_ff <= '0;
         char_ff      <= '0;
         sym_ff       <= '0;
         key_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         char_ff      <= char_in;
         sym_ff       <= sym_in;
         key_ff       <= key_in;
      end
   end

   assign next_rsp = '{char_position: char_in, phase: phase_in, key: key_in};

`ifndef ASSERT_OFF
   a_key_only_in_mark: assert property (@(posedge clock) disable iff (reset)
      key_ff == (phase_ff == PhaseMark))
      else $error("key level disagrees with the mark phase");

   a_post_at_message_end: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhasePost) |-> (char_ff == CharWidth'(MessageLength)))
      else $error("post message phase away from the end of the message");

   a_hold_without_tick: assert property (@(posedge clock) disable iff (reset)
      !(accept && tick) |=> ($stable(phase_ff) && $stable(remaining_ff)
                             && $stable(char_ff) && $stable(sym_ff)))
      else $error("keyer state moved without a tick");
`endif

endmodule

@@ rtl/mbs_result_reg.sv @@
// ----------------------------------------------------------------------------
// Morse beacon result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module mbs_result_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  mbs_pkg::rsp_type data_in,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic             space,
   output mbs_pkg::rsp_type data_out
);
   import mbs_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign data_out   = data_ff;

`ifndef ASSERT_OFF
   a_load_gives_result: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded item did not appear as a result");
`endif

endmodule

@@ rtl/morse_beacon_sequencer.sv @@
// ----------------------------------------------------------------------------
// Morse beacon sequencer
// Looping Morse beacon keyer stepped by millisecond tick items.
// ----------------------------------------------------------------------------
// Every input item carries one tick bit and yields exactly one result item
// holding the key level, the phase and the index of the character being sent.
// The block takes one item per clock cycle: the whole state update (countdown,
// phase step and code table lookup) is one pass of logic in front of the state
// registers, and a single result register decouples the two sides, so a new
// item is taken whenever that register is empty or its item is being taken.
// A result is offered in the cycle after its item is accepted. There is
// no clearing pass after reset; the timing registers come up at their
// documented defaults and may be rewritten while the block is idle.
module morse_beacon_sequencer (
   input  logic                              clock,
   input  logic                              reset,

   // Input items: tdata holds tick in bit 0, bits 7:1 are zero.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,

   // Result items: tdata holds key_level (bit 0), phase_code (bits 3:1),
   // char_position (bits 11:4); bits 15:12 are zero.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,

   // Timing register writes.
   input  logic                              csr_we,
   input  logic [mbs_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [mbs_pkg::DurWidth-1:0]      csr_wdata
);
   import mbs_pkg::*;

   cfg_type cfg;
   rsp_type next_rsp;
   rsp_type rsp_data;
   logic    accept;
   logic    space;

   // An item is taken whenever the result register has room for its answer.
   assign req_tready = space;
   assign accept     = req_tvalid && req_tready;

   mbs_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The keyer state advances only on accepted items; a zero tick holds it.
   mbs_keyer_core u_keyer_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .tick     (req_tdata[0]),
      .cfg      (cfg),
      .next_rsp (next_rsp)
   );

   mbs_result_reg u_result_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .data_in    (next_rsp),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .space      (space),
      .data_out   (rsp_data)
   );

   assign rsp_tdata = {4'b0000, rsp_data.char_position, rsp_data.phase, rsp_data.key};

endmodule

@@ dv/morse_beacon_sequencer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse beacon sequencer testbench
// Streams tick items into the keyer under several timing settings and checks
// every result item against a cycle-free predictor of the beacon sequence.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the phase, countdown, character and
// symbol indexes and the timing registers, and spells the message out of its
// own code table. Each accepted input item pushes one expected result; each
// accepted result item is compared field by field with the oldest one.
// The run opens with a few directed items under the reset timing, then goes
// through a series of settings (minimum, zero, mixed short durations and
// finally the largest durations), each followed by a burst of random ticks.
module morse_beacon_sequencer_test;
   import mbs_pkg::*;

   // Predictor and store of expected result items.
   class beacon_scoreboard;
      string            beacon_text = "GWOT.ENERGY";
      logic [15:0]      dot_ticks, dash_ticks, intra_ticks, inter_ticks, post_ticks;
      phase_type        beacon_phase;
      logic [15:0]      countdown;
      logic [7:0]       char_idx;
      logic [2:0]       sym_idx;
      logic             key_state;
      rsp_type          expected_levels[$];
      int               errors;

      function new();
         dot_ticks    = 16'd100;
         dash_ticks   = 16'd300;
         intra_ticks  = 16'd100;
         inter_ticks  = 16'd300;
         post_ticks   = 16'd5000;
         beacon_phase = PhaseBegin;
         countdown    = '0;
         char_idx     = '0;
         sym_idx      = '0;
         key_state    = 1'b0;
         errors       = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t ns: %s", $realtime, msg);
      endtask

      function void write_timing(logic [CsrIndexWidth-1:0] idx, logic [15:0] value);
         case (idx)
            RegDot:          dot_ticks   = value;
            RegDash:         dash_ticks  = value;
            RegIntraGap:     intra_ticks = value;
            RegInterCharGap: inter_ticks = value;
            RegPostMessage:  post_ticks  = value;
            default: ;
         endcase
      endfunction

      // Dots and dashes of the character at a message position; empty when
      // the position lies beyond the stored text.
      function string morse_of(logic [7:0] idx);
         string code;
         byte   ch;
         code = "";
         if (idx < beacon_text.len()) begin
            ch = beacon_text[idx];
            case (ch)
               "G": code = "--.";
               "W": code = ".--";
               "O": code = "---";
               "T": code = "-";
               ".": code = ".-.-.-";
               "E": code = ".";
               "N": code = "-.";
               "R": code = ".-.";
               "Y": code = "-.--";
               default: code = "";
            endcase
         end
         return code;
      endfunction

      function void start_mark(string code);
         key_state    = 1'b1;
         beacon_phase = PhaseMark;
         countdown    = (code[sym_idx] == "-") ? dash_ticks : dot_ticks;
      endfunction

      // After a character is done, either the next one follows a gap or the
      // message closes with the long silence.
      function void next_char();
         char_idx = char_idx + 8'd1;
         if (char_idx >= MessageLength) begin
            beacon_phase = PhasePost;
            countdown    = post_ticks;
         end else begin
            beacon_phase = PhaseInter;
            countdown    = inter_ticks;
         end
      endfunction

      function void fire();
         string code;
         code = morse_of(char_idx);
         case (beacon_phase)
            PhaseBegin: begin
               char_idx = '0;
               sym_idx  = '0;
               code     = morse_of(char_idx);
               if (code.len() == 0) begin
                  key_state    = 1'b0;
                  beacon_phase = PhaseInter;
                  countdown    = inter_ticks;
               end else begin
                  start_mark(code);
               end
            end
            PhaseMark: begin
               key_state = 1'b0;
               sym_idx   = sym_idx + 3'd1;
               if (sym_idx >= code.len()) begin
                  next_char();
               end else begin
                  beacon_phase = PhaseIntra;
                  countdown    = intra_ticks;
               end
            end
            PhaseIntra: start_mark(code);
            PhaseInter: begin
               sym_idx = '0;
               if (code.len() == 0) begin
                  key_state = 1'b0;
                  next_char();
               end else begin
                  start_mark(code);
               end
            end
            default: begin
               key_state    = 1'b0;
               beacon_phase = PhaseBegin;
               countdown    = '0;
            end
         endcase
      endfunction

      function void note_tick(logic tick);
         rsp_type level;
         if (tick) begin
            if (countdown != 0) countdown = countdown - 16'd1;
            if (countdown == 0) fire();
         end
         level.key           = key_state;
         level.phase         = beacon_phase;
         level.char_position = char_idx;
         expected_levels.push_back(level);
      endfunction

      task check_result(logic [15:0] data);
         rsp_type want;
         rsp_type got;
         got = data[11:0];
         if (expected_levels.size() == 0) begin
            report($sformatf("unexpected result item %h", data));
         end else begin
            want = expected_levels.pop_front();
            if (got.key !== want.key)
               report($sformatf("key_level %b, expected %b", got.key, want.key));
            if (got.phase !== want.phase)
               report($sformatf("phase_code %0d, expected %0d", got.phase, want.phase));
            if (got.char_position !== want.char_position)
               report($sformatf("char_position %0d, expected %0d",
                                got.char_position, want.char_position));
            if (data[15:12] !== 4'd0)
               report($sformatf("padding bits %b not zero", data[15:12]));
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [15:0]              rsp_tdata;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [DurWidth-1:0]      csr_wdata;

   beacon_scoreboard         sb;
   // When clear, both sides run flat out for the current setting.
   bit                       idling;

   morse_beacon_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Generous bound on the whole run; the slowest correct run is well under
   // a tenth of it.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Both handshakes are observed at the clock edge, before any of this
   // edge's updates land, so the order of processes does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_tick(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Result side: a random stall before each item while idling is on.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         stall = idling ? $urandom_range(0, 5) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Offers one tick item and waits until it is taken.
   task send_tick(logic tick);
      int gap;
      gap = idling ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, tick};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Withdraws the sender and waits until every expected item has arrived,
   // then lets the result register settle.
   task drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_levels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // The caller lowers the write enable once its batch of writes is done.
   task write_timing(logic [CsrIndexWidth-1:0] idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_timing(idx, value);
   endtask

   // Short durations keep the message cycling many times within the run;
   // zero must behave like one.
   function logic [15:0] short_duration();
      logic [15:0] value;
      if ($urandom_range(0, 3) != 0) value = 16'($urandom_range(0, 3));
      else value = 16'($urandom_range(4, 12));
      return value;
   endfunction

   task random_ticks(int count);
      for (int n = 0; n < count; n++) send_tick($urandom_range(0, 99) < 85);
   endtask

   initial begin
      logic [15:0] durations[5];
      int          setting;
      sb          = new();
      idling      = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset timing: held items show the reset state, the first tick fires
      // the begin phase at once and the first dash of G starts.
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // Settings: minimum, all zero, then mixed short ones. The countdown
      // loaded under the reset timing drains during the first burst.
      for (setting = 0; setting < 13; setting++) begin
         drain();
         for (int r = 0; r < 5; r++) begin
            if (setting == 0) durations[r] = 16'd1;
            else if (setting == 1) durations[r] = 16'd0;
            else durations[r] = short_duration();
         end
         write_timing(RegDot,          durations[0]);
         write_timing(RegDash,         durations[1]);
         write_timing(RegIntraGap,     durations[2]);
         write_timing(RegInterCharGap, durations[3]);
         write_timing(RegPostMessage,  durations[4]);
         // Writes to unused indexes must leave every timing untouched.
         if ($urandom_range(0, 1) == 1)
            write_timing(CsrIndexWidth'($urandom_range(RegPostMessage + 1,
                                                       2**CsrIndexWidth - 1)),
                         16'($urandom_range(0, 16'hFFFF)));
         csr_we <= 1'b0;
         idling = ($urandom_range(0, 3) != 0);
         random_ticks(setting == 0 ? 400 : 85);
      end

      // Largest durations: only the load of a full-scale countdown is
      // exercised, since running one out would take far too long.
      drain();
      write_timing(RegDot,          16'hFFFF);
      write_timing(RegDash,         16'hFFFF);
      write_timing(RegIntraGap,     16'hFFFF);
      write_timing(RegInterCharGap, 16'hFFFF);
      write_timing(RegPostMessage,  16'hFFFF);
      csr_we <= 1'b0;
      idling = 1'b1;
      random_ticks(40);

      drain();
      repeat (4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mbs_pkg.sv
rtl/mbs_csr_regs.sv
rtl/mbs_keyer_core.sv
rtl/mbs_result_reg.sv
rtl/morse_beacon_sequencer.sv
dv/morse_beacon_sequencer_test.sv
